### rtl/core/i2cm_pkg.sv
// Package for the EEPROM access master: request/result structs, bus state codes.
// No dependencies.
package i2cm_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_DATA  = 2'd3;

  localparam logic [1:0] REG_DEVSEL = 2'd0;
  localparam logic [1:0] REG_PAGE   = 2'd1;
  localparam logic [1:0] REG_TPP    = 2'd2;
  localparam logic [1:0] REG_POLL   = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NACK = 2'd1;
  localparam logic [1:0] ERR_POLL = 2'd2;

  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;
  localparam logic [7:0] PAGE_RESET = 8'h7F;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_POLL_START = 4'd1;
  localparam logic [3:0] S_POLL_CTRL  = 4'd2;
  localparam logic [3:0] S_ADDR_HI    = 4'd3;
  localparam logic [3:0] S_ADDR_LO    = 4'd4;
  localparam logic [3:0] S_RESTART    = 4'd5;
  localparam logic [3:0] S_READ_CTRL  = 4'd6;
  localparam logic [3:0] S_READ_BYTE  = 4'd7;
  localparam logic [3:0] S_WAIT_DATA  = 4'd8;
  localparam logic [3:0] S_WRITE_DATA = 4'd9;
  localparam logic [3:0] S_STOP       = 4'd10;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [15:0] count;
    logic [7:0]  data;
    logic        sda_in;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_enable;
    logic       write_protect;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;
  } res_t;

endpackage

### rtl/core/i2c_eeprom_access_master.sv
// Top level of the EEPROM access master: config registers, front queue, bus engine.
// Depends on i2cm_pkg, i2cm_front, i2cm_engine.
//
// Usage: every request on the in channel is one item: a tick (carrying sampled SDA),
// a begin read, a begin write or a write data byte. Every accepted request yields
// exactly one result on the out channel, with the SCL/SDA/write protect levels
// after that request plus read byte, done and error flags.
// Throughput: one request per clock while results are taken; the engine's state update
// is the loop that sets it. A request passes through the two-entry request queue and
// then the result register when nothing stalls.
// When the receiver stalls the result register holds and the queue fills; in_ready
// drops once two requests are waiting. Reset (rst, synchronous) returns the bus to
// idle (SCL high, SDA released, write protect high) and loads register defaults:
// device_select 0, page_mask 0x7F, ticks_per_phase 2, poll_limit 0.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken.
module i2c_eeprom_access_master #(
  parameter int ADDR_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::res_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  logic [2:0]     dev_sel;
  logic [7:0]     page_mask;
  logic [7:0]     tpp;
  logic [15:0]    poll_limit;
  logic           q_valid;
  logic           q_ready;
  i2cm_pkg::req_t q_req;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_sel <= 3'd0; page_mask <= i2cm_pkg::PAGE_RESET; tpp <= 8'd2; poll_limit <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        i2cm_pkg::REG_DEVSEL: dev_sel <= cfg_data[2:0];
        i2cm_pkg::REG_PAGE:   page_mask <= cfg_data[7:0];
        i2cm_pkg::REG_TPP:    tpp <= cfg_data[7:0];
        i2cm_pkg::REG_POLL:   poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  i2cm_engine #(.ADDR_WIDTH(ADDR_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_data),
    .dev_sel(dev_sel), .page_mask(page_mask), .tpp(tpp), .poll_limit(poll_limit)
  );

endmodule

### rtl/core/i2cm_front.sv
// Front end: input skid queue (two entries) ahead of the bus engine.
// Depends on i2cm_pkg.
module i2cm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::req_t  in_req,
  output logic            q_valid,
  input  logic            q_ready,
  output i2cm_pkg::req_t  q_req
);

  i2cm_pkg::req_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_req;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/core/i2cm_engine.sv
// Back end: bus sequencer, one request per cycle unless out_ready stalls, registered result output.
// Depends on i2cm_pkg.
module i2cm_engine #(
  parameter int ADDR_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  i2cm_pkg::req_t  q_req,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::res_t  out_res,
  input  logic [2:0]      dev_sel,
  input  logic [7:0]      page_mask,
  input  logic [7:0]      tpp,
  input  logic [15:0]     poll_limit
);

  logic [3:0]             st, st_next;
  logic [1:0]             quarter, quarter_next;
  logic [7:0]             timer, timer_next;
  logic [3:0]             bitc, bitc_next;
  logic [7:0]             shift, shift_next;
  logic [ADDR_WIDTH-1:0]  addr, addr_next;
  logic [COUNT_WIDTH-1:0] left, left_next;
  logic [15:0]            polls, polls_next;
  logic [7:0]             held, held_next;
  logic                   held_v, held_v_next;
  logic                   is_wr, is_wr_next;
  logic                   ack, ack_next;
  logic [1:0]             err, err_next;
  i2cm_pkg::res_t         res;
  logic                   go;

  assign q_ready = !out_valid || out_ready;
  assign go      = q_valid && q_ready;

  function automatic logic is_byte(input logic [3:0] s);
    return s == i2cm_pkg::S_POLL_CTRL || s == i2cm_pkg::S_ADDR_HI ||
           s == i2cm_pkg::S_ADDR_LO || s == i2cm_pkg::S_READ_CTRL ||
           s == i2cm_pkg::S_READ_BYTE || s == i2cm_pkg::S_WRITE_DATA;
  endfunction

  // next state of the sequencer for one request
  always_comb begin
    logic [7:0]             tp;
    logic [7:0]             tinc;
    logic [3:0]             tgt;
    logic                   ent;
    logic                   pend;
    logic                   hi;
    logic [COUNT_WIDTH-1:0] pending;
    tp   = (tpp == 8'd0) ? 8'd1 : tpp;
    tinc = timer + 8'd1;
    tgt  = st;
    ent  = 1'b0;
    st_next = st; quarter_next = quarter; timer_next = timer; bitc_next = bitc;
    shift_next = shift; addr_next = addr; left_next = left; polls_next = polls;
    held_next = held; held_v_next = held_v; is_wr_next = is_wr; ack_next = ack;
    err_next = err;
    res = '0;
    unique case (q_req.func)
      i2cm_pkg::FUNC_TICK: begin
        if (st == i2cm_pkg::S_WAIT_DATA) begin
          if (held_v) begin
            tgt = i2cm_pkg::S_WRITE_DATA; ent = 1'b1; held_v_next = 1'b0;
          end
        end else if (st != i2cm_pkg::S_IDLE) begin
          timer_next = tinc;
          if (tinc >= tp) begin
            timer_next = 8'd0;
            if (quarter == 2'd2 && is_byte(st)) begin
              if (!bitc[3]) begin
                if (st == i2cm_pkg::S_READ_BYTE) shift_next = {shift[6:0], q_req.sda_in};
              end else begin
                ack_next = !q_req.sda_in;
              end
            end
            quarter_next = quarter + 2'd1;
            if (quarter == 2'd3) begin
              if (is_byte(st) && !bitc[3]) begin
                bitc_next = bitc + 4'd1;
              end else begin
                ent = 1'b1;
                unique case (st)
                  i2cm_pkg::S_POLL_START: tgt = i2cm_pkg::S_POLL_CTRL;
                  i2cm_pkg::S_RESTART:    tgt = i2cm_pkg::S_READ_CTRL;
                  i2cm_pkg::S_READ_CTRL:  tgt = i2cm_pkg::S_READ_BYTE;
                  i2cm_pkg::S_POLL_CTRL: begin
                    if (ack_next) tgt = i2cm_pkg::S_ADDR_HI;
                    else begin
                      if (polls != 16'hFFFF) polls_next = polls + 16'd1;
                      if (poll_limit != 16'd0 && polls_next >= poll_limit) begin
                        err_next = i2cm_pkg::ERR_POLL; tgt = i2cm_pkg::S_STOP;
                      end else tgt = i2cm_pkg::S_POLL_START;
                    end
                  end
                  i2cm_pkg::S_ADDR_HI: begin
                    if (is_wr && !ack_next) begin
                      err_next = i2cm_pkg::ERR_NACK; tgt = i2cm_pkg::S_STOP;
                    end else tgt = i2cm_pkg::S_ADDR_LO;
                  end
                  i2cm_pkg::S_ADDR_LO: begin
                    if (is_wr && !ack_next) begin
                      err_next = i2cm_pkg::ERR_NACK; tgt = i2cm_pkg::S_STOP;
                    end else tgt = is_wr ? i2cm_pkg::S_WAIT_DATA : i2cm_pkg::S_RESTART;
                  end
                  i2cm_pkg::S_READ_BYTE: begin
                    res.read_valid = 1'b1;
                    res.read_byte  = shift_next;
                    res.read_last  = (left <= COUNT_WIDTH'(1));
                    if (left != '0) left_next = left - COUNT_WIDTH'(1);
                    addr_next = addr + ADDR_WIDTH'(1);
                    tgt = (left_next == '0) ? i2cm_pkg::S_STOP : i2cm_pkg::S_READ_BYTE;
                  end
                  i2cm_pkg::S_WRITE_DATA: begin
                    if (!ack_next) begin
                      err_next = i2cm_pkg::ERR_NACK; tgt = i2cm_pkg::S_STOP;
                    end else begin
                      if (left != '0) left_next = left - COUNT_WIDTH'(1);
                      addr_next = addr + ADDR_WIDTH'(1);
                      tgt = (left_next == '0 || (addr[7:0] & page_mask) == page_mask)
                            ? i2cm_pkg::S_STOP : i2cm_pkg::S_WAIT_DATA;
                    end
                  end
                  i2cm_pkg::S_STOP: begin
                    if (err == i2cm_pkg::ERR_NONE && is_wr && left != '0) begin
                      polls_next = 16'd0; tgt = i2cm_pkg::S_POLL_START;
                    end else begin
                      res.done_res = 1'b1; res.error_code = err;
                      err_next = i2cm_pkg::ERR_NONE; is_wr_next = 1'b0;
                      tgt = i2cm_pkg::S_IDLE;
                    end
                  end
                  default: tgt = i2cm_pkg::S_IDLE;
                endcase
              end
            end
          end
        end
      end
      i2cm_pkg::FUNC_DATA: begin
        if (st != i2cm_pkg::S_IDLE && is_wr && !held_v) begin
          held_v_next = 1'b1; held_next = q_req.data;
        end
      end
      default: begin
        if (st == i2cm_pkg::S_IDLE && q_req.count[COUNT_WIDTH-1:0] != '0) begin
          is_wr_next = (q_req.func == i2cm_pkg::FUNC_WRITE);
          addr_next  = q_req.address[ADDR_WIDTH-1:0];
          left_next  = q_req.count[COUNT_WIDTH-1:0];
          polls_next = 16'd0; held_v_next = 1'b0; err_next = i2cm_pkg::ERR_NONE;
          ack_next = 1'b0; tgt = i2cm_pkg::S_POLL_START; ent = 1'b1;
        end
      end
    endcase
    // entering a new bus unit
    if (ent) begin
      st_next = tgt; quarter_next = 2'd0; bitc_next = 4'd0; timer_next = 8'd0;
      case (tgt)
        i2cm_pkg::S_POLL_CTRL:  shift_next = i2cm_pkg::CTRL_WRITE | {4'd0, dev_sel, 1'b0};
        i2cm_pkg::S_READ_CTRL:  shift_next = i2cm_pkg::CTRL_READ | {4'd0, dev_sel, 1'b0};
        i2cm_pkg::S_ADDR_HI:    shift_next = 8'((32'(addr_next)) >> 8);
        i2cm_pkg::S_ADDR_LO:    shift_next = addr_next[7:0];
        i2cm_pkg::S_READ_BYTE:  shift_next = 8'd0;
        i2cm_pkg::S_WRITE_DATA: shift_next = held;
        default: ;
      endcase
    end
    // bus drive for the new state
    hi = (quarter_next == 2'd1 || quarter_next == 2'd2);
    res.scl = 1'b1; res.sda_out = 1'b1; res.sda_enable = 1'b0;
    case (st_next)
      i2cm_pkg::S_IDLE: ;
      i2cm_pkg::S_WAIT_DATA: begin
        res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b1;
      end
      i2cm_pkg::S_POLL_START, i2cm_pkg::S_RESTART: begin
        res.sda_enable = 1'b1; res.scl = hi; res.sda_out = !quarter_next[1];
      end
      i2cm_pkg::S_STOP: begin
        res.sda_enable = 1'b1; res.scl = (quarter_next != 2'd0);
        res.sda_out = quarter_next[1];
      end
      i2cm_pkg::S_READ_BYTE: begin
        res.scl = hi;
        if (bitc_next[3]) begin
          res.sda_enable = 1'b1; res.sda_out = !(left_next > COUNT_WIDTH'(1));
        end
      end
      default: begin
        res.scl = hi;
        if (!bitc_next[3]) begin
          res.sda_enable = 1'b1; res.sda_out = shift_next[3'd7 - bitc_next[2:0]];
        end
      end
    endcase
    pending = left_next;
    if (st_next == i2cm_pkg::S_WRITE_DATA && pending != '0) pending = pending - COUNT_WIDTH'(1);
    pend = (st_next != i2cm_pkg::S_IDLE) && is_wr_next;
    res.write_protect = !pend;
    res.busy_res = (st_next != i2cm_pkg::S_IDLE);
    res.data_request = pend && err_next == i2cm_pkg::ERR_NONE && pending != '0 && !held_v_next;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= i2cm_pkg::S_IDLE; quarter <= 2'd0; timer <= 8'd0; bitc <= 4'd0;
      shift <= 8'd0; addr <= '0; left <= '0; polls <= 16'd0; held_v <= 1'b0;
      is_wr <= 1'b0; ack <= 1'b0; err <= i2cm_pkg::ERR_NONE;
    end else if (go) begin
      st <= st_next; quarter <= quarter_next; timer <= timer_next; bitc <= bitc_next;
      shift <= shift_next; addr <= addr_next; left <= left_next; polls <= polls_next;
      held_v <= held_v_next; is_wr <= is_wr_next; ack <= ack_next; err <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) held <= held_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_res <= res;
  end

endmodule
